// ----- rtl/rlps_pkg.sv -----
`default_nettype none

package rlps_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_SEND  = 1'b1
    } kind_t;

    localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [2:0] REG_RED_SLOT    = 3'd1;
    localparam logic [2:0] REG_GREEN_SLOT  = 3'd2;
    localparam logic [2:0] REG_BLUE_SLOT   = 3'd3;
    localparam logic [2:0] REG_PIXEL_COUNT = 3'd4;

    localparam logic [7:0] CODE_ONE  = 8'hF8;
    localparam logic [7:0] CODE_ZERO = 8'hC0;

    localparam int         PIXEL_BITS = 24;
    localparam logic [4:0] LAST_BIT   = 5'(PIXEL_BITS - 1);

    localparam logic [7:0] RESET_BRIGHTNESS  = 8'd255;
    localparam logic [1:0] RESET_RED_SLOT    = 2'd1;
    localparam logic [1:0] RESET_GREEN_SLOT  = 2'd0;
    localparam logic [1:0] RESET_BLUE_SLOT   = 2'd2;
    localparam logic [8:0] RESET_PIXEL_COUNT = 9'd8;

    // Exact floor(p / 255) for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] sum;
        sum = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb_led_pixel_serializer.sv -----
// Write request: the scaled colors are registered on acceptance and stored in the cycle after;
// the next request is taken once the control is back in idle. Send request: the stored word
// is loaded in the LOAD state, then 24 code bytes follow, one per cycle while out_ready is high;
// requests are handled one at a time. The registered read port of the store is the reason for LOAD.
// Reset returns the registers to their defaults and the control to idle; pixel store contents
// are undefined until written.
`default_nettype none

module rgb_led_pixel_serializer #(
    parameter int MAX_PIXELS = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_data,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] pixel_index,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] spi_byte,
    output logic            pixel_last,
    output logic            frame_last
);

    import rlps_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int EXT_W = 17;

    state_t state_reg, state_next;

    logic [7:0]  brightness_reg;
    logic [1:0]  red_slot_reg;
    logic [1:0]  green_slot_reg;
    logic [1:0]  blue_slot_reg;
    logic [8:0]  pixel_count_reg;

    logic [15:0] red_prod_reg, red_prod_next;
    logic [15:0] green_prod_reg, green_prod_next;
    logic [15:0] blue_prod_reg, blue_prod_next;
    logic [7:0]  index_reg, index_next;
    logic        in_range_reg, in_range_next;
    logic        frame_end_reg, frame_end_next;
    logic [23:0] shift_reg, shift_next;
    logic [4:0]  count_reg, count_next;

    logic [EXT_W-1:0] index_ext;
    logic             in_range;
    logic             frame_end;
    logic [7:0]       slots [3];
    logic [23:0]      wr_word;
    logic [EXT_W-1:0] wr_index_ext;
    logic             ram_we;
    logic [23:0]      ram_rdata;
    logic             in_fire;
    logic             out_fire;

    assign index_ext = {9'b0, pixel_index};
    assign in_range = index_ext < EXT_W'(MAX_PIXELS);
    assign frame_end = ({1'b0, pixel_index} + 9'd1) == pixel_count_reg;
    assign wr_index_ext = {9'b0, index_reg};

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_valid = (state_reg == ST_SEND);
    assign out_fire = out_valid && out_ready;

    assign spi_byte = shift_reg[23] ? CODE_ONE : CODE_ZERO;
    assign pixel_last = (count_reg == LAST_BIT);
    assign frame_last = pixel_last && frame_end_reg;

    // Later channels win a shared slot; a slot value of three drops the channel.
    always_comb
    begin
        slots[0] = 8'd0;
        slots[1] = 8'd0;
        slots[2] = 8'd0;
        if (red_slot_reg != 2'd3)
        begin
            slots[red_slot_reg] = div255(red_prod_reg);
        end
        if (green_slot_reg != 2'd3)
        begin
            slots[green_slot_reg] = div255(green_prod_reg);
        end
        if (blue_slot_reg != 2'd3)
        begin
            slots[blue_slot_reg] = div255(blue_prod_reg);
        end
        wr_word = {slots[0], slots[1], slots[2]};
    end

    assign ram_we = (state_reg == ST_WRITE) && in_range_reg;

    rlps_ram #(
        .WIDTH  (24),
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_index_ext[ADDR_W-1:0]),
        .wdata (wr_word),
        .raddr (index_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= RESET_BRIGHTNESS;
            red_slot_reg    <= RESET_RED_SLOT;
            green_slot_reg  <= RESET_GREEN_SLOT;
            blue_slot_reg   <= RESET_BLUE_SLOT;
            pixel_count_reg <= RESET_PIXEL_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIGHTNESS:  brightness_reg  <= cfg_data[7:0];
                REG_RED_SLOT:    red_slot_reg    <= cfg_data[1:0];
                REG_GREEN_SLOT:  green_slot_reg  <= cfg_data[1:0];
                REG_BLUE_SLOT:   blue_slot_reg   <= cfg_data[1:0];
                REG_PIXEL_COUNT: pixel_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_prod_reg   <= red_prod_next;
        green_prod_reg <= green_prod_next;
        blue_prod_reg  <= blue_prod_next;
        index_reg      <= index_next;
        in_range_reg   <= in_range_next;
        frame_end_reg  <= frame_end_next;
        shift_reg      <= shift_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        red_prod_next   = red_prod_reg;
        green_prod_next = green_prod_reg;
        blue_prod_next  = blue_prod_reg;
        index_next      = index_reg;
        in_range_next   = in_range_reg;
        frame_end_next  = frame_end_reg;
        shift_next      = shift_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    index_next     = pixel_index;
                    in_range_next  = in_range;
                    frame_end_next = frame_end;
                    if (kind_t'(kind) == KIND_WRITE)
                    begin
                        red_prod_next   = 16'(red) * 16'(brightness_reg);
                        green_prod_next = 16'(green) * 16'(brightness_reg);
                        blue_prod_next  = 16'(blue) * 16'(brightness_reg);
                        state_next      = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                shift_next = in_range_reg ? ram_rdata : 24'd0;
                count_next = 5'd0;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_fire)
                begin
                    shift_next = {shift_reg[22:0], 1'b0};
                    if (count_reg == LAST_BIT)
                    begin
                        count_next = 5'd0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rlps_ram.sv -----
`default_nettype none

module rlps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sim/tb_rgb_led_pixel_serializer.sv -----
`timescale 1ns / 1ps

module tb_rgb_led_pixel_serializer;
    import rlps_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] code;
        logic       pix_end;
        logic       frame_end;
    } led_code_t;

    localparam logic [1:0] NO_SLOT = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       kind = 1'b0;
    logic [7:0] pixel_index = '0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] spi_byte;
    logic       pixel_last;
    logic       frame_last;

    rgb_led_pixel_serializer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .spi_byte    (spi_byte),
        .pixel_last  (pixel_last),
        .frame_last  (frame_last)
    );

    always #5 clk = ~clk;

    logic [7:0]  bright_cfg = RESET_BRIGHTNESS;
    logic [1:0]  red_pos    = RESET_RED_SLOT;
    logic [1:0]  green_pos  = RESET_GREEN_SLOT;
    logic [1:0]  blue_pos   = RESET_BLUE_SLOT;
    logic [8:0]  chain_len  = RESET_PIXEL_COUNT;
    logic [23:0] pixel_mem [256];
    bit          filled [256];

    pixel_req_t  pending_reqs [$];
    led_code_t   expected_codes [$];
    pixel_req_t  shown_req;
    int          queued_reqs = 0;
    int          accepted_reqs = 0;
    int          write_reqs = 0;
    int          send_reqs = 0;
    int          reg_writes = 0;
    int          codes_checked = 0;
    int          mismatches = 0;
    bit          calm = 1'b0;

    function automatic logic [7:0] scaled(input logic [7:0] c);
        logic [15:0] p;
        p = 16'(c) * 16'(bright_cfg);
        return 8'(p / 16'd255);
    endfunction

    function automatic logic [23:0] pack_word(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        logic [7:0] lane [3];
        lane[0] = '0;
        lane[1] = '0;
        lane[2] = '0;
        if (red_pos != NO_SLOT) lane[red_pos] = scaled(r);
        if (green_pos != NO_SLOT) lane[green_pos] = scaled(g);
        if (blue_pos != NO_SLOT) lane[blue_pos] = scaled(b);
        return {lane[0], lane[1], lane[2]};
    endfunction

    function automatic void absorb_request(input pixel_req_t rq);
        logic [23:0] word;
        led_code_t   c;
        if (rq.kind == KIND_WRITE) begin
            pixel_mem[rq.idx] = pack_word(rq.r, rq.g, rq.b);
        end
        else begin
            word = pixel_mem[rq.idx];
            for (int k = 0; k < PIXEL_BITS; k++) begin
                c.code      = word[PIXEL_BITS - 1 - k] ? CODE_ONE : CODE_ZERO;
                c.pix_end   = (k == PIXEL_BITS - 1);
                c.frame_end = c.pix_end && ({1'b0, rq.idx} + 9'd1 == chain_len);
                expected_codes.push_back(c);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : drive_requests
        logic offer;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                absorb_request(shown_req);
                accepted_reqs++;
            end
            if (!in_valid || in_ready) begin
                offer = pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 28);
                if (offer) begin
                    shown_req = pending_reqs.pop_front();
                    in_valid    <= 1'b1;
                    kind        <= shown_req.kind;
                    pixel_index <= shown_req.idx;
                    red         <= shown_req.r;
                    green       <= shown_req.g;
                    blue        <= shown_req.b;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : check_codes
        led_code_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected code byte %02h last=%b frame=%b",
                                 $realtime, spi_byte, pixel_last, frame_last);
                end
                else begin
                    want = expected_codes.pop_front();
                    codes_checked++;
                    if (spi_byte !== want.code || pixel_last !== want.pix_end ||
                        frame_last !== want.frame_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %02h/%b/%b got %02h/%b/%b",
                                     $realtime, want.code, want.pix_end, want.frame_end,
                                     spi_byte, pixel_last, frame_last);
                    end
                end
            end
            out_ready <= calm || $urandom_range(99) >= 28;
        end
    end

    task automatic drain();
        while (accepted_reqs != queued_reqs || expected_codes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_reg(input logic [2:0] index, input logic [8:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_BRIGHTNESS:  bright_cfg = data[7:0];
            REG_RED_SLOT:    red_pos = data[1:0];
            REG_GREEN_SLOT:  green_pos = data[1:0];
            REG_BLUE_SLOT:   blue_pos = data[1:0];
            REG_PIXEL_COUNT: chain_len = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(input logic [7:0] br, input logic [1:0] rs, input logic [1:0] gs,
                         input logic [1:0] bs, input logic [8:0] count);
        drain();
        set_reg(REG_BRIGHTNESS, {1'($urandom), br});
        set_reg(REG_RED_SLOT, {7'($urandom), rs});
        set_reg(REG_GREEN_SLOT, {7'($urandom), gs});
        set_reg(REG_BLUE_SLOT, {7'($urandom), bs});
        set_reg(REG_PIXEL_COUNT, count);
    endtask

    task automatic add_request(input kind_t k, input logic [7:0] idx, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        pixel_req_t rq;
        rq = '{kind: k, idx: idx, r: r, g: g, b: b};
        pending_reqs.push_back(rq);
        queued_reqs++;
        if (k == KIND_WRITE) begin
            filled[idx] = 1'b1;
            write_reqs++;
        end
        else begin
            send_reqs++;
        end
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_send(input logic [7:0] idx);
        if (!filled[idx])
            add_request(KIND_WRITE, idx, rand_level(), rand_level(), rand_level());
        add_request(KIND_SEND, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_setup();
        logic [7:0] br;
        logic [8:0] count;
        case ($urandom_range(3))
            0:       br = 8'd0;
            1:       br = 8'd255;
            default: br = 8'($urandom_range(255));
        endcase
        case ($urandom_range(5))
            0:       count = 9'd1;
            1:       count = 9'd256;
            2:       count = 9'($urandom_range(511, 257));
            3:       count = 9'd0;
            default: count = 9'($urandom_range(16, 1));
        endcase
        setup(br, 2'($urandom), 2'($urandom), 2'($urandom), count);
    endtask

    task automatic random_traffic(input int n);
        logic [7:0] idx;
        for (int i = 0; i < n; i++) begin
            if (chain_len >= 9'd1 && chain_len <= 9'd256 && $urandom_range(5) == 0)
                idx = 8'(chain_len - 9'd1);
            else if ($urandom_range(99) < 60)
                idx = 8'($urandom_range(15));
            else
                idx = 8'($urandom_range(255));
            if ($urandom_range(1))
                add_send(idx);
            else
                add_request(KIND_WRITE, idx, rand_level(), rand_level(), rand_level());
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_request(KIND_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        add_request(KIND_WRITE, 8'd255, 8'h00, 8'h00, 8'h00);
        add_request(KIND_WRITE, 8'd7, 8'hA5, 8'h5A, 8'h3C);
        add_request(KIND_WRITE, 8'd128, 8'h01, 8'h80, 8'hFE);
        add_send(8'd0);
        add_send(8'd255);
        add_send(8'd7);
        add_send(8'd128);

        // All three colors share the first slot, so blue wins there.
        setup(8'd255, 2'd0, 2'd0, 2'd0, 9'd256);
        add_request(KIND_WRITE, 8'd3, 8'h12, 8'h34, 8'hFF);
        add_send(8'd3);
        add_send(8'd255);
        drain();
        set_reg(REG_BRIGHTNESS, 9'd0);
        add_request(KIND_WRITE, 8'd4, 8'hFF, 8'hFF, 8'hFF);
        add_send(8'd4);

        // Red has no slot, green and blue collide, the first slot stays empty.
        setup(8'd128, NO_SLOT, 2'd2, 2'd2, 9'd1);
        add_request(KIND_WRITE, 8'd0, 8'hFF, 8'h80, 8'h7F);
        add_send(8'd0);
        add_send(8'd7);

        setup(8'd1, 2'd2, 2'd1, 2'd0, 9'd0);
        for (int k = 1; k <= 3; k++)
            set_reg(REG_PIXEL_COUNT + 3'(k), 9'($urandom));
        add_request(KIND_WRITE, 8'd200, 8'hFF, 8'hFF, 8'hFF);
        add_send(8'd200);
        add_send(8'd255);

        setup(8'd254, 2'd1, 2'd2, 2'd0, 9'd511);
        add_request(KIND_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        add_send(8'd255);

        for (int p = 0; p < 5; p++) begin
            random_setup();
            calm = (p == 2);
            random_traffic(20);
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Covered %0d pixel writes and %0d sends, %0d code bytes checked,",
                 write_reqs, send_reqs, codes_checked);
        $display("with %0d register writes and %0d mismatches.", reg_writes, mismatches);
        if (mismatches == 0 && expected_codes.size() == 0)
            $display("tb_rgb_led_pixel_serializer: PASS");
        else
            $display("tb_rgb_led_pixel_serializer: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_rgb_led_pixel_serializer: FAIL");
        $finish;
    end

endmodule
